@@ src/tsw_pkg.sv @@
// ----------------------------------------------------------------------------
// tsw_pkg: shared types and constants of the temperature smoother
// Widths, microcode word, micro-program and saturation helper.
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int TEMP_WIDTH   = 17;

    localparam int JUMP_W  = 16;
    localparam int WEIGHT_W = 9;
    localparam int WLEN_W  = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int LOG_D   = $clog2(WINDOW_DEPTH);
    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? LOG_D : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = TEMP_WIDTH + LOG_D;
    localparam int ACC_W   = TEMP_WIDTH + WEIGHT_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);
    localparam int ITER_W  = (CNT_W > DIV_CNT_W) ? CNT_W : DIV_CNT_W;
    localparam int LEN_CMP_W = CNT_W + WLEN_W;
    localparam int BLEND_SHIFT = 8;

    localparam logic [JUMP_W-1:0]   JUMP_RESET  = 16'd3840;
    localparam logic [WEIGHT_W-1:0] BLEND_RESET = 9'd77;
    localparam logic [WLEN_W-1:0]   WLEN_RESET  = 4'd5;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

    typedef logic signed [TEMP_WIDTH-1:0] temp_t;
    typedef logic signed [ACC_W-1:0]      acc_t;

    localparam acc_t TEMP_MAX_EXT = {{(ACC_W-TEMP_WIDTH+1){1'b0}}, {(TEMP_WIDTH-1){1'b1}}};
    localparam acc_t TEMP_MIN_EXT = {{(ACC_W-TEMP_WIDTH+1){1'b1}}, {(TEMP_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JUMP_LIMIT    = 2'd0,
        CFG_BLEND_WEIGHT  = 2'd1,
        CFG_WINDOW_LENGTH = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_FETCH, OP_SEED, OP_LIMIT, OP_READ, OP_SUM, OP_DIVINIT,
        OP_DIVSTEP, OP_MEAN, OP_MULA, OP_MULB, OP_BLEND, OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT, C_JUMP, C_WAIT_IN, C_IF_NONPOS, C_IF_SEEDED, C_IF_ITER_ZERO,
        C_LOOP, C_WAIT_OUT
    } cond_t;

    typedef enum logic [3:0] {
        S_FETCH, S_CHECK, S_ROUTE, S_SEED, S_LIMIT, S_PRIME, S_SUM, S_DIVINIT,
        S_DIVSTEP, S_MEAN, S_MULA, S_MULB, S_BLEND, S_EMIT
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic in_fire;
        logic out_block;
        logic sample_pos;
        logic seeded;
        logic iter_zero;
        logic iter_last;
    } dp_status_t;

    // Micro-program: one control word per step
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        unique case (pc)
            S_FETCH:   w = '{OP_FETCH,   C_WAIT_IN,      S_FETCH};
            S_CHECK:   w = '{OP_NOP,     C_IF_NONPOS,    S_EMIT};
            S_ROUTE:   w = '{OP_NOP,     C_IF_SEEDED,    S_LIMIT};
            S_SEED:    w = '{OP_SEED,    C_JUMP,         S_EMIT};
            S_LIMIT:   w = '{OP_LIMIT,   C_NEXT,         S_PRIME};
            S_PRIME:   w = '{OP_READ,    C_IF_ITER_ZERO, S_DIVINIT};
            S_SUM:     w = '{OP_SUM,     C_LOOP,         S_SUM};
            S_DIVINIT: w = '{OP_DIVINIT, C_NEXT,         S_DIVSTEP};
            S_DIVSTEP: w = '{OP_DIVSTEP, C_LOOP,         S_DIVSTEP};
            S_MEAN:    w = '{OP_MEAN,    C_NEXT,         S_MULA};
            S_MULA:    w = '{OP_MULA,    C_NEXT,         S_MULB};
            S_MULB:    w = '{OP_MULB,    C_NEXT,         S_BLEND};
            S_BLEND:   w = '{OP_BLEND,   C_NEXT,         S_EMIT};
            S_EMIT:    w = '{OP_EMIT,    C_WAIT_OUT,     S_FETCH};
            default:   w = '{OP_NOP,     C_JUMP,         S_FETCH};
        endcase
        return w;
    endfunction

    function automatic temp_t sat_temp(input acc_t v);
        temp_t r;
        if (v > TEMP_MAX_EXT)
        begin
            r = TEMP_MAX_EXT[TEMP_WIDTH-1:0];
        end
        else if (v < TEMP_MIN_EXT)
        begin
            r = TEMP_MIN_EXT[TEMP_WIDTH-1:0];
        end
        else
        begin
            r = v[TEMP_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/tsw_in_if.sv @@
// ----------------------------------------------------------------------------
// tsw_in_if: sample input channel
// Valid/ready channel carrying one raw temperature per transfer.
// ----------------------------------------------------------------------------
interface tsw_in_if;
    logic            valid;
    logic            ready;
    tsw_pkg::temp_t  sample_temp;

    modport source (output valid, output sample_temp, input ready);
    modport sink   (input valid, input sample_temp, output ready);
endinterface

@@ src/tsw_out_if.sv @@
// ----------------------------------------------------------------------------
// tsw_out_if: smoothed output channel
// Valid/ready channel carrying one smoothed temperature per transfer.
// ----------------------------------------------------------------------------
interface tsw_out_if;
    logic            valid;
    logic            ready;
    tsw_pkg::temp_t  smoothed_temp;

    modport source (output valid, output smoothed_temp, input ready);
    modport sink   (input valid, input smoothed_temp, output ready);
endinterface

@@ src/tsw_seq.sv @@
// ----------------------------------------------------------------------------
// tsw_seq: microcode sequencer
// Step counter, control store and conditional jump logic.
// ----------------------------------------------------------------------------
module tsw_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsw_pkg::dp_status_t  st,
    output tsw_pkg::ucode_t      ctrl
);

    tsw_pkg::step_t pc_reg;
    tsw_pkg::step_t pc_next;
    tsw_pkg::step_t pc_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= tsw_pkg::S_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        ctrl   = tsw_pkg::ucode_rom(pc_reg);
        pc_inc = tsw_pkg::step_t'(pc_reg + 4'd1);
        unique case (ctrl.cond)
            tsw_pkg::C_NEXT:         pc_next = pc_inc;
            tsw_pkg::C_JUMP:         pc_next = ctrl.target;
            tsw_pkg::C_WAIT_IN:      pc_next = st.in_fire ? pc_inc : pc_reg;
            tsw_pkg::C_IF_NONPOS:    pc_next = st.sample_pos ? pc_inc : ctrl.target;
            tsw_pkg::C_IF_SEEDED:    pc_next = st.seeded ? ctrl.target : pc_inc;
            tsw_pkg::C_IF_ITER_ZERO: pc_next = st.iter_zero ? ctrl.target : pc_inc;
            tsw_pkg::C_LOOP:         pc_next = st.iter_last ? pc_inc : ctrl.target;
            tsw_pkg::C_WAIT_OUT:     pc_next = st.out_block ? pc_reg : ctrl.target;
            default:                 pc_next = tsw_pkg::S_FETCH;
        endcase
    end

    // Input transfers happen only in the fetch step
    a_fetch_only: assert property (@(posedge clk) disable iff (!rst_n)
        st.in_fire |-> pc_reg == tsw_pkg::S_FETCH)
        else $error("input transfer outside fetch step");

    // A delivered result returns the program to fetch
    a_emit_return: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == tsw_pkg::S_EMIT && !st.out_block) |=> pc_reg == tsw_pkg::S_FETCH)
        else $error("emit step did not return to fetch");

endmodule

@@ src/tsw_datapath.sv @@
// ----------------------------------------------------------------------------
// tsw_datapath: smoother datapath
// Registers, sample window, accumulator, serial divider and blend multiplier.
// ----------------------------------------------------------------------------
module tsw_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tsw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tsw_pkg::CFG_W-1:0]            cfg_data,
    input  tsw_pkg::ucode_t                      ctrl,
    output tsw_pkg::dp_status_t                  st,
    tsw_in_if.sink                               in_ch,
    tsw_out_if.source                            out_ch
);

    // configuration
    logic [tsw_pkg::JUMP_W-1:0]   jump_reg;
    logic [tsw_pkg::WEIGHT_W-1:0] weight_reg;
    logic [tsw_pkg::WLEN_W-1:0]   wlen_reg;

    // control state
    tsw_pkg::temp_t               sm_reg, sm_next;
    logic                         seeded_reg, seeded_next;
    logic [tsw_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tsw_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [tsw_pkg::SLOT_W-1:0]   rd_reg, rd_next;
    logic [tsw_pkg::ITER_W-1:0]   iter_reg, iter_next;
    logic                         out_valid_reg, out_valid_next;

    // payload
    tsw_pkg::temp_t               sample_reg;
    tsw_pkg::acc_t                acc_reg, acc_next;
    logic [tsw_pkg::SUM_W-1:0]    quo_reg, quo_next;
    logic [tsw_pkg::CNT_W-1:0]    rem_reg, rem_next;
    logic                         neg_reg, neg_next;
    tsw_pkg::temp_t               mean_reg, mean_next;
    tsw_pkg::temp_t               out_data_reg;
    tsw_pkg::temp_t               rd_data_reg;
    tsw_pkg::temp_t               win_mem [tsw_pkg::WINDOW_DEPTH];

    logic                         in_fire, out_block, emit_load;
    logic                         mem_we, mem_re;
    tsw_pkg::temp_t               mem_wdata;

    tsw_pkg::acc_t                s_ext, sm_ext, jl_ext, hi_lim, lo_lim, lim_raw;
    tsw_pkg::temp_t               lim_val;
    logic [tsw_pkg::CNT_W-1:0]    len_eff;
    logic [tsw_pkg::CNT_W:0]      cnt_inc;
    logic [tsw_pkg::CNT_W-1:0]    cnt_upd;
    logic [tsw_pkg::SLOT_W-1:0]   slot_inc, rd_dec, slot_dec;
    tsw_pkg::acc_t                acc_mag;
    logic [tsw_pkg::CNT_W:0]      div_shift, div_diff;
    logic                         div_ge;
    tsw_pkg::temp_t               mean_mag;
    logic [tsw_pkg::WEIGHT_W-1:0] w_eff, w_comp, mul_w;
    tsw_pkg::temp_t               mul_x;
    tsw_pkg::acc_t                prod;

    assign in_ch.ready   = (ctrl.op == tsw_pkg::OP_FETCH);
    assign in_fire       = in_ch.valid && in_ch.ready;
    assign out_block     = out_valid_reg && !out_ch.ready;
    assign emit_load     = (ctrl.op == tsw_pkg::OP_EMIT) && !out_block;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.smoothed_temp = out_data_reg;

    assign st.in_fire    = in_fire;
    assign st.out_block  = out_block;
    assign st.sample_pos = !sample_reg[tsw_pkg::TEMP_WIDTH-1] && (sample_reg != '0);
    assign st.seeded     = seeded_reg;
    assign st.iter_zero  = (iter_reg == '0);
    assign st.iter_last  = (iter_reg == tsw_pkg::ITER_W'(1));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_reg   <= tsw_pkg::JUMP_RESET;
            weight_reg <= tsw_pkg::BLEND_RESET;
            wlen_reg   <= tsw_pkg::WLEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsw_pkg::CFG_JUMP_LIMIT:    jump_reg   <= cfg_data[tsw_pkg::JUMP_W-1:0];
                tsw_pkg::CFG_BLEND_WEIGHT:  weight_reg <= cfg_data[tsw_pkg::WEIGHT_W-1:0];
                tsw_pkg::CFG_WINDOW_LENGTH: wlen_reg   <= cfg_data[tsw_pkg::WLEN_W-1:0];
                default:                    jump_reg   <= jump_reg;
            endcase
        end
    end

    // shared arithmetic
    always_comb
    begin
        s_ext   = tsw_pkg::ACC_W'(sample_reg);
        sm_ext  = tsw_pkg::ACC_W'(sm_reg);
        jl_ext  = $signed(tsw_pkg::ACC_W'(jump_reg));
        hi_lim  = sm_ext + jl_ext;
        lo_lim  = sm_ext - jl_ext;
        if (s_ext > hi_lim)
        begin
            lim_raw = hi_lim;
        end
        else if (s_ext < lo_lim)
        begin
            lim_raw = lo_lim;
        end
        else
        begin
            lim_raw = s_ext;
        end
        lim_val = tsw_pkg::sat_temp(lim_raw);

        // clamp window length to 1..depth
        if (wlen_reg == '0)
        begin
            len_eff = tsw_pkg::CNT_W'(1);
        end
        else if (tsw_pkg::LEN_CMP_W'(wlen_reg) > tsw_pkg::LEN_CMP_W'(tsw_pkg::WINDOW_DEPTH))
        begin
            len_eff = tsw_pkg::CNT_W'(tsw_pkg::WINDOW_DEPTH);
        end
        else
        begin
            len_eff = tsw_pkg::CNT_W'(wlen_reg);
        end
        cnt_inc = {1'b0, cnt_reg} + (tsw_pkg::CNT_W+1)'(1);
        cnt_upd = (cnt_inc > {1'b0, len_eff}) ? len_eff : cnt_inc[tsw_pkg::CNT_W-1:0];

        slot_inc = (slot_reg == tsw_pkg::SLOT_W'(tsw_pkg::WINDOW_DEPTH - 1))
                   ? '0 : slot_reg + tsw_pkg::SLOT_W'(1);
        slot_dec = (slot_reg == '0)
                   ? tsw_pkg::SLOT_W'(tsw_pkg::WINDOW_DEPTH - 1) : slot_reg - tsw_pkg::SLOT_W'(1);
        rd_dec   = (rd_reg == '0)
                   ? tsw_pkg::SLOT_W'(tsw_pkg::WINDOW_DEPTH - 1) : rd_reg - tsw_pkg::SLOT_W'(1);

        // one restoring division step: one quotient bit
        acc_mag   = acc_reg[tsw_pkg::ACC_W-1] ? -acc_reg : acc_reg;
        div_shift = {rem_reg, quo_reg[tsw_pkg::SUM_W-1]};
        div_diff  = div_shift - {1'b0, cnt_reg};
        div_ge    = (div_shift >= {1'b0, cnt_reg});
        mean_mag  = quo_reg[tsw_pkg::TEMP_WIDTH-1:0];

        // single blend multiplier, shared by both products
        w_eff  = (weight_reg > tsw_pkg::WEIGHT_FULL) ? tsw_pkg::WEIGHT_FULL : weight_reg;
        w_comp = tsw_pkg::WEIGHT_FULL - w_eff;
        mul_w  = (ctrl.op == tsw_pkg::OP_MULA) ? w_eff : w_comp;
        mul_x  = (ctrl.op == tsw_pkg::OP_MULA) ? mean_reg : sm_reg;
        prod   = $signed({1'b0, mul_w}) * mul_x;
    end

    // microcode decode
    always_comb
    begin
        sm_next     = sm_reg;
        seeded_next = seeded_reg;
        cnt_next    = cnt_reg;
        slot_next   = slot_reg;
        rd_next     = rd_reg;
        iter_next   = iter_reg;
        acc_next    = acc_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        mean_next   = mean_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wdata   = sample_reg;
        unique case (ctrl.op)
            tsw_pkg::OP_SEED:
            begin
                sm_next     = sample_reg;
                seeded_next = 1'b1;
                cnt_next    = tsw_pkg::CNT_W'(1);
                slot_next   = slot_inc;
                mem_we      = 1'b1;
            end
            tsw_pkg::OP_LIMIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = lim_val;
                slot_next = slot_inc;
                cnt_next  = cnt_upd;
                acc_next  = tsw_pkg::ACC_W'(lim_val);
                rd_next   = slot_dec;
                iter_next = tsw_pkg::ITER_W'(cnt_upd) - tsw_pkg::ITER_W'(1);
            end
            tsw_pkg::OP_READ:
            begin
                mem_re  = 1'b1;
                rd_next = rd_dec;
            end
            tsw_pkg::OP_SUM:
            begin
                acc_next  = acc_reg + tsw_pkg::ACC_W'(rd_data_reg);
                mem_re    = 1'b1;
                rd_next   = rd_dec;
                iter_next = iter_reg - tsw_pkg::ITER_W'(1);
            end
            tsw_pkg::OP_DIVINIT:
            begin
                quo_next  = acc_mag[tsw_pkg::SUM_W-1:0];
                rem_next  = '0;
                neg_next  = acc_reg[tsw_pkg::ACC_W-1];
                iter_next = tsw_pkg::ITER_W'(tsw_pkg::SUM_W);
            end
            tsw_pkg::OP_DIVSTEP:
            begin
                rem_next  = div_ge ? div_diff[tsw_pkg::CNT_W-1:0]
                                   : div_shift[tsw_pkg::CNT_W-1:0];
                quo_next  = {quo_reg[tsw_pkg::SUM_W-2:0], div_ge};
                iter_next = iter_reg - tsw_pkg::ITER_W'(1);
            end
            tsw_pkg::OP_MEAN:  mean_next = neg_reg ? -mean_mag : mean_mag;
            tsw_pkg::OP_MULA:  acc_next  = prod;
            tsw_pkg::OP_MULB:  acc_next  = acc_reg + prod;
            tsw_pkg::OP_BLEND: sm_next   = tsw_pkg::sat_temp(acc_reg >>> tsw_pkg::BLEND_SHIFT);
            default:           mean_next = mean_reg;
        endcase

        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg        <= '0;
            seeded_reg    <= 1'b0;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            rd_reg        <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sm_reg        <= sm_next;
            seeded_reg    <= seeded_next;
            cnt_reg       <= cnt_next;
            slot_reg      <= slot_next;
            rd_reg        <= rd_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= in_ch.sample_temp;
        end
        if (emit_load)
        begin
            out_data_reg <= sm_reg;
        end
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
    end

    // sample window: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[slot_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= win_mem[rd_reg];
        end
    end

    a_unseeded_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !seeded_reg |-> cnt_reg == '0)
        else $error("window holds entries before seeding");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |-> (cnt_reg != '0 && cnt_reg <= tsw_pkg::CNT_W'(tsw_pkg::WINDOW_DEPTH)))
        else $error("window entry count out of range");

    a_iter_live: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == tsw_pkg::OP_SUM || ctrl.op == tsw_pkg::OP_DIVSTEP) |-> iter_reg != '0)
        else $error("loop step with exhausted iteration count");

    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> (out_valid_reg && out_data_reg == $past(sm_reg)))
        else $error("result register not loaded with smoothed value");

endmodule

@@ src/temperature_slew_window_ema_smoother.sv @@
// ----------------------------------------------------------------------------
// temperature_slew_window_ema_smoother: slew-limited moving-window smoother
// Top level: microcode sequencer driving the smoothing datapath.
// ----------------------------------------------------------------------------
// Takes one signed temperature per input transfer (1/256 degree C) and returns
// exactly one smoothed temperature per input transfer, in order. A sample at or
// below zero changes nothing and returns the current smoothed value (zero
// before the first positive sample). The first positive sample seeds the
// smoothed value and the window. Each later sample is clamped to within
// jump_limit of the smoothed value, pushed into a window of the last
// window_length samples (0 acts as 1, values above the window depth act as the
// depth), averaged with truncation toward zero, and blended as
// (w*mean + (256-w)*old) >>> 8, w = blend_weight capped at 256.
// One item at a time: no new sample is taken until the result of the last one
// has been loaded into the output register. The serial divider produces one
// quotient bit per step over the 20-bit window sum, and the window memory's
// single read port gives one entry per cycle. A result waiting in the output
// register while the sink stalls holds the sequencer in its emit step;
// configuration writes are taken any time and must only be issued while no
// item is in flight.
// ----------------------------------------------------------------------------
module temperature_slew_window_ema_smoother (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsw_pkg::CFG_W-1:0]       cfg_data,
    tsw_in_if.sink                          in_ch,
    tsw_out_if.source                       out_ch
);

    // control word of the current step, and datapath flags fed back for jumps
    tsw_pkg::ucode_t     ctrl;
    tsw_pkg::dp_status_t st;

    // Step counter and control store: advance, hold or jump per control word
    tsw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl)
    );

    // Window, accumulator, divider and blend; transfers on both channels
    tsw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .st        (st),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the temperature smoother
// Drives raw samples over the input channel and compares every smoothed
// transfer with a local slew, window and blend predictor. Runs a directed
// table first, then random phases under several register settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 38;
    localparam int DIR_ROWS       = 14;
    localparam int FIXED_PHASES   = 7;
    localparam int OWED_DEPTH     = 16;
    localparam longint TEMP_HI    = (longint'(1) <<< (tsw_pkg::TEMP_WIDTH - 1)) - 1;
    localparam longint TEMP_LO    = -TEMP_HI - 1;

    // One row of the directed table: a raw sample, and where the answer is
    // plain to see, the smoothed value typed in by hand.
    typedef struct {
        tsw_pkg::temp_t sample;
        bit             pinned;
        tsw_pkg::temp_t pinned_val;
    } dir_row_t;

    // One register setting for a phase of the run
    typedef struct {
        logic [tsw_pkg::JUMP_W-1:0]   jump;
        logic [tsw_pkg::WEIGHT_W-1:0] weight;
        logic [tsw_pkg::WLEN_W-1:0]   wlen;
    } reg_set_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [tsw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tsw_pkg::CFG_W-1:0]     cfg_data;

    tsw_in_if  in_ch ();
    tsw_out_if out_ch ();

    temperature_slew_window_ema_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow copies of the block's registers and smoothing state
    logic [tsw_pkg::JUMP_W-1:0]   jump_reg;
    logic [tsw_pkg::WEIGHT_W-1:0] weight_reg;
    logic [tsw_pkg::WLEN_W-1:0]   wlen_reg;
    longint                       ema_val;
    bit                           ema_seeded;
    longint                       hist [tsw_pkg::WINDOW_DEPTH];
    int                           hist_count;
    int                           hist_slot;

    // Smoothed values still owed by the block, oldest first: a ring with a
    // write count advanced by the sender and a read count by the sink
    tsw_pkg::temp_t               owed_mem [OWED_DEPTH];
    int                           owed_wr = 0;
    int                           owed_rd = 0;
    int                           mismatch_count = 0;
    int                           idle_cycles = 0;

    // Gap switches, changed per phase by the stimulus process
    bit                           send_gaps_on;
    bit                           sink_stalls_on;

    dir_row_t                     dir_tab [DIR_ROWS];
    reg_set_t                     set_tab [FIXED_PHASES];

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Owed result ring
    // ------------------------------------------------------------------------
    function automatic int owed_level();
        return owed_wr - owed_rd;
    endfunction

    function automatic void owe_result(input tsw_pkg::temp_t v);
        owed_mem[owed_wr % OWED_DEPTH] = v;
        owed_wr = owed_wr + 1;
    endfunction

    function automatic tsw_pkg::temp_t take_owed();
        tsw_pkg::temp_t v;
        v = owed_mem[owed_rd % OWED_DEPTH];
        owed_rd = owed_rd + 1;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_temp(input longint v);
        if (v > TEMP_HI)
        begin
            return TEMP_HI;
        end
        if (v < TEMP_LO)
        begin
            return TEMP_LO;
        end
        return v;
    endfunction

    // Advance the shadow state by one sample and return the smoothed value
    function automatic tsw_pkg::temp_t smooth_predict(input tsw_pkg::temp_t raw);
        longint s;
        longint lim;
        longint jl;
        longint sum;
        longint mean;
        longint w;
        longint t;
        int     len;
        int     slot;
        int     i;
        s = longint'(raw);
        // Non-positive samples are discarded; report the current value
        if (s <= 0)
        begin
            return tsw_pkg::temp_t'(ema_val);
        end
        // First good sample seeds the average and the window
        if (!ema_seeded)
        begin
            ema_val = s;
            hist[hist_slot] = s;
            hist_slot = (hist_slot + 1) % tsw_pkg::WINDOW_DEPTH;
            hist_count = 1;
            ema_seeded = 1'b1;
            return tsw_pkg::temp_t'(s);
        end
        // Clamp the step away from the current smoothed value
        jl = longint'(jump_reg);
        if (s - ema_val > jl)
        begin
            lim = ema_val + jl;
        end
        else if (s - ema_val < -jl)
        begin
            lim = ema_val - jl;
        end
        else
        begin
            lim = s;
        end
        lim = clamp_temp(lim);
        // Length zero behaves as one, anything past the depth as the depth
        len = int'(wlen_reg);
        if (len == 0)
        begin
            len = 1;
        end
        if (len > tsw_pkg::WINDOW_DEPTH)
        begin
            len = tsw_pkg::WINDOW_DEPTH;
        end
        hist[hist_slot] = lim;
        hist_slot = (hist_slot + 1) % tsw_pkg::WINDOW_DEPTH;
        hist_count = hist_count + 1;
        if (hist_count > len)
        begin
            hist_count = len;
        end
        sum = 0;
        slot = hist_slot;
        for (i = 0; i < hist_count; i++)
        begin
            slot = (slot + tsw_pkg::WINDOW_DEPTH - 1) % tsw_pkg::WINDOW_DEPTH;
            sum = sum + hist[slot];
        end
        // Signed division truncates toward zero, as the hardware mean does
        mean = sum / longint'(hist_count);
        w = (weight_reg > tsw_pkg::WEIGHT_FULL) ? longint'(tsw_pkg::WEIGHT_FULL)
                                                : longint'(weight_reg);
        t = w * mean + (256 - w) * ema_val;
        // Arithmetic shift rounds toward minus infinity
        ema_val = clamp_temp(t >>> tsw_pkg::BLEND_SHIFT);
        return tsw_pkg::temp_t'(ema_val);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 12)) : 0;
    endfunction

    // Present one sample, hold it until the transfer, and log the outcome.
    // Entered and left at a falling edge; valid is lowered only for a gap.
    task automatic send_sample(input tsw_pkg::temp_t v, input bit pinned,
                               input tsw_pkg::temp_t pinned_val);
        int             gap;
        tsw_pkg::temp_t want;
        gap = draw_gap(send_gaps_on);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sample_temp <= v;
        do
        begin
            @(posedge clk);
        end
        while (!(in_ch.valid && in_ch.ready));
        want = smooth_predict(v);
        if (pinned)
        begin
            want = pinned_val;
        end
        owe_result(want);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed result has been taken
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (owed_level() != 0)
        begin
            @(negedge clk);
        end
        // Let the sequencer settle back into its fetch step
        repeat (4) @(negedge clk);
    endtask

    // Write all three registers on consecutive cycles; block must be idle
    task automatic write_regs(input reg_set_t rs);
        cfg_we    <= 1'b1;
        cfg_index <= tsw_pkg::CFG_JUMP_LIMIT;
        cfg_data  <= tsw_pkg::CFG_W'(rs.jump);
        @(negedge clk);
        cfg_index <= tsw_pkg::CFG_BLEND_WEIGHT;
        cfg_data  <= tsw_pkg::CFG_W'(rs.weight);
        @(negedge clk);
        cfg_index <= tsw_pkg::CFG_WINDOW_LENGTH;
        cfg_data  <= tsw_pkg::CFG_W'(rs.wlen);
        @(negedge clk);
        cfg_we    <= 1'b0;
        jump_reg   = rs.jump;
        weight_reg = rs.weight;
        wlen_reg   = rs.wlen;
        @(negedge clk);
    endtask

    // Random sample, weighted toward valid readings near the current value
    // so that slew clamping and window averaging are exercised hard.
    function automatic tsw_pkg::temp_t pick_sample();
        int     pick;
        longint span;
        longint c;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return tsw_pkg::temp_t'(-1);
                2:       return tsw_pkg::temp_t'(TEMP_LO);
                default: return tsw_pkg::temp_t'(-longint'($urandom_range(1, 65536)));
            endcase
        end
        else if (pick < 50)
        begin
            span = longint'(jump_reg) + 50;
            c = ema_val + longint'($urandom_range(0, 2 * span)) - span;
            if (c < 1)
            begin
                c = 1;
            end
            if (c > TEMP_HI)
            begin
                c = TEMP_HI;
            end
            return tsw_pkg::temp_t'(c);
        end
        else if (pick < 75)
        begin
            return tsw_pkg::temp_t'($urandom_range(1, 65535));
        end
        else if (pick < 90)
        begin
            return tsw_pkg::temp_t'($urandom_range(1, 255));
        end
        return ($urandom_range(0, 1) != 0) ? tsw_pkg::temp_t'(TEMP_HI) : tsw_pkg::temp_t'(1);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall at random, compare each transfer with the oldest
    // owed value.
    // ------------------------------------------------------------------------
    initial
    begin
        int             gap;
        tsw_pkg::temp_t got;
        tsw_pkg::temp_t want;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(sink_stalls_on);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(out_ch.valid && out_ch.ready));
            got = out_ch.smoothed_temp;
            if (owed_level() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected smoothed_temp transfer: expected none, actual %0d",
                         $time, got);
            end
            else
            begin
                want = take_owed();
                if (got !== want)
                begin
                    mismatch_count++;
                    $display("%0t: smoothed_temp mismatch: expected %0d, actual %0d",
                             $time, want, got);
                end
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on either channel for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reg_set_t rs;
        int       p;
        int       k;

        // Known values on every input from time zero
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = tsw_pkg::CFG_JUMP_LIMIT;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.sample_temp = '0;
        send_gaps_on      = 1'b1;
        sink_stalls_on    = 1'b1;

        // Shadow state after reset
        jump_reg   = tsw_pkg::JUMP_RESET;
        weight_reg = tsw_pkg::BLEND_RESET;
        wlen_reg   = tsw_pkg::WLEN_RESET;
        ema_val    = 0;
        ema_seeded = 1'b0;
        hist_count = 0;
        hist_slot  = 0;
        for (k = 0; k < tsw_pkg::WINDOW_DEPTH; k++)
        begin
            hist[k] = 0;
        end

        // Directed samples under the reset settings. Non-positive readings
        // before seeding return zero; the first good one seeds; a repeat of
        // the seed leaves the average where it is. Then full-scale swings
        // up and down to hit the slew clamp both ways.
        dir_tab = '{
            '{tsw_pkg::temp_t'(0),       1'b1, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(TEMP_LO), 1'b1, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(-1),      1'b1, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(1000),    1'b1, tsw_pkg::temp_t'(1000)},
            '{tsw_pkg::temp_t'(0),       1'b1, tsw_pkg::temp_t'(1000)},
            '{tsw_pkg::temp_t'(1000),    1'b1, tsw_pkg::temp_t'(1000)},
            '{tsw_pkg::temp_t'(TEMP_HI), 1'b0, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(1),       1'b0, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(TEMP_LO), 1'b0, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(43690),   1'b0, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(21845),   1'b0, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(TEMP_HI), 1'b0, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(1),       1'b0, tsw_pkg::temp_t'(0)},
            '{tsw_pkg::temp_t'(0),       1'b0, tsw_pkg::temp_t'(0)}
        };

        // Register settings for the first phases: the extremes, weights
        // past full scale, and window lengths of zero and past the depth.
        set_tab = '{
            '{16'd0,     9'd0,   4'd1},
            '{16'd65535, 9'd256, 4'd8},
            '{16'd0,     9'd256, 4'd8},
            '{16'd65535, 9'd0,   4'd1},
            '{16'd1,     9'd511, 4'd0},
            '{16'd3840,  9'd300, 4'd15},
            '{16'd100,   9'd128, 4'd3}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            send_sample(dir_tab[k].sample, dir_tab[k].pinned, dir_tab[k].pinned_val);
        end

        // Random phases: drain, reprogram, then run a batch of samples
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            drain_results();
            if (p < FIXED_PHASES)
            begin
                rs = set_tab[p];
            end
            else
            begin
                rs.jump   = ($urandom_range(0, 1) != 0)
                            ? tsw_pkg::JUMP_W'($urandom_range(0, 2000))
                            : tsw_pkg::JUMP_W'($urandom_range(0, 65535));
                rs.weight = tsw_pkg::WEIGHT_W'($urandom_range(0, 511));
                rs.wlen   = tsw_pkg::WLEN_W'($urandom_range(0, 15));
            end
            write_regs(rs);

            // Rotate the gap pattern so both sides see stretches with and
            // without idling.
            case (p % 4)
                0:
                begin
                    send_gaps_on   = 1'b1;
                    sink_stalls_on = 1'b1;
                end
                1:
                begin
                    send_gaps_on   = 1'b0;
                    sink_stalls_on = 1'b0;
                end
                2:
                begin
                    send_gaps_on   = 1'b1;
                    sink_stalls_on = 1'b0;
                end
                default:
                begin
                    send_gaps_on   = 1'b0;
                    sink_stalls_on = 1'b1;
                end
            endcase

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // Once mid-phase, hold the sender until the block is empty
                if (p == FIXED_PHASES + 1 && k == PHASE_ITEMS / 2)
                begin
                    drain_results();
                end
                send_sample(pick_sample(), 1'b0, '0);
            end
        end

        // Wait for the last results, then give the block time to misbehave
        in_ch.valid <= 1'b0;
        while (owed_level() != 0)
        begin
            @(negedge clk);
        end
        repeat (50) @(posedge clk);

        if (mismatch_count == 0 && owed_level() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
